### src/lapsh_pkg.sv
// ----------------------------------------------------------------------------
// lapsh_pkg
// Shared types and constants for the 3x3 Laplacian sharpen block.
// ----------------------------------------------------------------------------
package lapsh_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int MAX_HEIGHT       = 4096;

    localparam int SAMPLE_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_CFG_W = 12;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 12;
    localparam int NC_W        = 3;
    localparam int CH_W        = 2;
    localparam int CH_SLOTS    = 4;
    localparam int ACC_W       = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 operation;
        logic [SAMPLE_W-1:0] pixel_sample;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sharpened_sample;
        logic                frame_last;
    } out_item_t;

    // what travels from the sequencer to the filter core with each request
    typedef struct packed {
        logic                is_sample;
        logic                emit;
        logic                interior;
        logic                last;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
    } stage_tag_t;

endpackage

### src/lapsh_line_ram.sv
// ----------------------------------------------------------------------------
// lapsh_line_ram
// One line store: single write port, one registered read port.
// ----------------------------------------------------------------------------
module lapsh_line_ram
    import lapsh_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [0:DEPTH-1];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lapsh_ctrl.sv
// ----------------------------------------------------------------------------
// lapsh_ctrl
// Configuration registers, raster counters and the input stage register.
// ----------------------------------------------------------------------------
module lapsh_ctrl
    import lapsh_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int AW           = $clog2(MAX_WIDTH * MAX_CHANNELS),
    parameter int CW           = $clog2(MAX_WIDTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    input  logic                   a_take,
    output logic                   a_valid,
    output stage_tag_t             a_tag,
    output logic [AW-1:0]          a_addr,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr
);

    logic [CW-1:0]       w_eff_reg, w_eff_next;
    logic [HEIGHT_W-1:0] h_eff_reg, h_eff_next;
    logic [NC_W-1:0]     nc_eff_reg, nc_eff_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                done_reg, done_next;
    logic                a_valid_reg, a_valid_next;
    stage_tag_t          a_tag_reg, tag_next;
    logic [AW-1:0]       a_addr_reg;

    logic        accept, take_sample, load;
    logic        ch_wrap, col_wrap, row_wrap, drain_last;
    logic [31:0] w_in, h_in, nc_in;

    assign s_ready = !a_valid_reg || a_take;
    assign accept  = s_valid && s_ready;

    assign ch_wrap    = ({1'b0, ch_reg} == nc_eff_reg - NC_W'(1));
    assign col_wrap   = (col_reg == w_eff_reg - CW'(1));
    assign row_wrap   = ({1'b0, row_reg} == h_eff_reg - HEIGHT_W'(1));
    assign drain_last = done_reg && (col_reg == w_eff_reg) && ch_wrap;

    // once the last sample is in, every request (sample or flush) drains one result
    assign take_sample = !done_reg && (s_item.operation == OP_SAMPLE);
    assign load        = take_sample || done_reg;

    assign w_in  = 32'(cfg_wdata[WIDTH_CFG_W-1:0]);
    assign h_in  = 32'(cfg_wdata[HEIGHT_W-1:0]);
    assign nc_in = 32'(cfg_wdata[NC_W-1:0]);

    always_comb begin
        w_eff_next  = w_eff_reg;
        h_eff_next  = h_eff_reg;
        nc_eff_next = nc_eff_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ch_next     = ch_reg;
        addr_next   = addr_reg;
        done_next   = done_reg;

        tag_next.is_sample = take_sample;
        tag_next.emit      = done_reg || (row_reg >= ROW_W'(2))
                             || (row_reg == ROW_W'(1) && col_reg != '0);
        tag_next.interior  = !done_reg && (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
        tag_next.last      = drain_last;
        tag_next.ch        = ch_reg;
        tag_next.sample    = s_item.pixel_sample;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    w_eff_next = (w_in < 32'd3) ? CW'(3) :
                                 (w_in > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_in);
                end
                CFG_IMAGE_HEIGHT: begin
                    h_eff_next = (h_in < 32'd3) ? HEIGHT_W'(3) :
                                 (h_in > 32'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) :
                                 HEIGHT_W'(h_in);
                end
                CFG_CHANNEL_COUNT: begin
                    nc_eff_next = (nc_in < 32'd1) ? NC_W'(1) :
                                  (nc_in > 32'(MAX_CHANNELS)) ? NC_W'(MAX_CHANNELS) :
                                  NC_W'(nc_in);
                end
                default: ;
            endcase
            if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT
                    || cfg_index == CFG_CHANNEL_COUNT) begin
                row_next  = '0;
                col_next  = '0;
                ch_next   = '0;
                addr_next = '0;
                done_next = 1'b0;
            end
        end else if (accept && take_sample) begin
            if (ch_wrap) begin
                ch_next = '0;
                if (col_wrap) begin
                    col_next  = '0;
                    addr_next = '0;
                    if (row_wrap) begin
                        // last sample of the frame: counters restart for the drain
                        row_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next  = col_reg + CW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end else begin
                ch_next   = ch_reg + CH_W'(1);
                addr_next = addr_reg + AW'(1);
            end
        end else if (accept && done_reg) begin
            // drain walks w+1 pixels of nc channels
            if (drain_last) begin
                col_next  = '0;
                ch_next   = '0;
                done_next = 1'b0;
            end else if (ch_wrap) begin
                ch_next  = '0;
                col_next = col_reg + CW'(1);
            end else begin
                ch_next = ch_reg + CH_W'(1);
            end
        end

        if (accept && load) begin
            a_valid_next = 1'b1;
        end else if (a_take) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg   <= CW'(640);
            h_eff_reg   <= HEIGHT_W'(480);
            nc_eff_reg  <= NC_W'(1);
            row_reg     <= '0;
            col_reg     <= '0;
            ch_reg      <= '0;
            addr_reg    <= '0;
            done_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            w_eff_reg   <= w_eff_next;
            h_eff_reg   <= h_eff_next;
            nc_eff_reg  <= nc_eff_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            ch_reg      <= ch_next;
            addr_reg    <= addr_next;
            done_reg    <= done_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && load) begin
            a_tag_reg  <= tag_next;
            a_addr_reg <= addr_reg;
        end
    end

    assign rd_en   = accept && take_sample;
    assign rd_addr = addr_reg;
    assign a_valid = a_valid_reg;
    assign a_tag   = a_tag_reg;
    assign a_addr  = a_addr_reg;

    a_ch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, ch_reg} < nc_eff_reg)
        else $error("channel counter beyond channel count");

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !done_reg |-> col_reg < w_eff_reg)
        else $error("column counter beyond row width");

    a_drain_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> addr_reg == '0)
        else $error("line store address moved during drain");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_take |=> a_valid_reg && $stable(a_tag_reg))
        else $error("stage register lost a request");

endmodule

### src/lapsh_core.sv
// ----------------------------------------------------------------------------
// lapsh_core
// Per-channel window, sharpen arithmetic and the result register.
// ----------------------------------------------------------------------------
module lapsh_core
    import lapsh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                a_valid,
    input  stage_tag_t          a_tag,
    input  logic [SAMPLE_W-1:0] rd_top,
    input  logic [SAMPLE_W-1:0] rd_mid,
    output logic                a_take,
    output logic                wr_en,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_item
);

    // only the parts of each 3x3 window that the kernel reads are kept
    logic [SAMPLE_W-1:0] left_mid_reg [CH_SLOTS];
    logic [SAMPLE_W-1:0] top_reg      [CH_SLOTS];
    logic [SAMPLE_W-1:0] mid_reg      [CH_SLOTS];
    logic [SAMPLE_W-1:0] bot_reg      [CH_SLOTS];

    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg;

    logic                out_free;
    logic [SAMPLE_W-1:0] centre, left, up, down;
    logic [ACC_W-1:0]    centre5, acc;
    logic [SAMPLE_W-1:0] clamped;

    assign out_free = !m_valid_reg || m_ready;
    assign a_take   = a_valid && (!a_tag.emit || out_free);
    assign wr_en    = a_take && a_tag.is_sample;

    assign centre = mid_reg[a_tag.ch];
    assign left   = left_mid_reg[a_tag.ch];
    assign up     = top_reg[a_tag.ch];
    assign down   = bot_reg[a_tag.ch];

    always_comb begin
        centre5 = {2'b00, centre, 2'b00} + ACC_W'(centre);
        acc     = centre5 - ACC_W'(left) - ACC_W'(rd_mid) - ACC_W'(up) - ACC_W'(down);
        if (acc[ACC_W-1]) begin
            clamped = '0;
        end else if (acc[ACC_W-2:SAMPLE_W] != '0) begin
            clamped = '1;
        end else begin
            clamped = acc[SAMPLE_W-1:0];
        end

        if (a_take && a_tag.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            left_mid_reg[a_tag.ch] <= mid_reg[a_tag.ch];
            top_reg[a_tag.ch]      <= rd_top;
            mid_reg[a_tag.ch]      <= rd_mid;
            bot_reg[a_tag.ch]      <= a_tag.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take && a_tag.emit) begin
            m_item_reg.sharpened_sample <= a_tag.interior ? clamped : '0;
            m_item_reg.frame_last       <= a_tag.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_last_on_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.frame_last |-> m_item_reg.sharpened_sample == '0)
        else $error("frame end result not on the border");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_item_reg))
        else $error("waiting result overwritten");

    a_drain_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        a_take && a_tag.last |-> !wr_en)
        else $error("line store written by a drain request");

endmodule

### src/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 sharpen (5*centre minus the four orthogonal neighbours).
// ----------------------------------------------------------------------------
// Takes one channel sample per request in raster order, channels interleaved,
// and returns one result per request once a line plus one pixel has arrived;
// each request is held in the stage register, and its result then in the
// output register. A new request is taken every cycle while the result side
// keeps up, so the rate is one sample per clock; the only loop is the
// read-modify-write of the two line stores (MAX_WIDTH*MAX_CHANNELS entries
// each), one read and one write per cycle. Border rows and columns give zero.
// After the last sample of a frame, each further request (flush or sample)
// drains one trailing result; the final one carries frame_last. A flush sent
// before the frame's last sample is taken and dropped. Any configuration
// write restarts the frame.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3
    import lapsh_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);

    logic                a_take, a_valid, rd_en, wr_en;
    stage_tag_t          a_tag;
    logic [AW-1:0]       a_addr, rd_addr;
    logic [SAMPLE_W-1:0] rd_top, rd_mid;

    lapsh_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .a_take    (a_take),
        .a_valid   (a_valid),
        .a_tag     (a_tag),
        .a_addr    (a_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // previous line: gets the new sample
    lapsh_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_prev (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (a_addr),
        .wr_data (a_tag.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_mid)
    );

    // line before that: gets what the previous line held
    lapsh_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_prev_prev (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (a_addr),
        .wr_data (rd_mid),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_top)
    );

    lapsh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_valid (a_valid),
        .a_tag   (a_tag),
        .rd_top  (rd_top),
        .rd_mid  (rd_mid),
        .a_take  (a_take),
        .wr_en   (wr_en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### tb/lapsh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lapsh_checker
// Watches the sharpen block's ports, predicts each result and compares.
// ----------------------------------------------------------------------------
// Keeps its own line stores, per-channel windows, frame counters and register
// copies. Every taken request is run through the predictor and any result it
// causes is queued; every taken result is checked field by field against the
// oldest queued one. Mismatches are counted and handed up to the top.
// ----------------------------------------------------------------------------
module lapsh_checker
    import lapsh_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_item,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_item,
    output int                     failures,
    output int                     outstanding
);

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;

    logic [WIDTH_CFG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [NC_W-1:0]        chan_reg;

    logic [SAMPLE_W-1:0] row_above     [STORE_DEPTH];
    logic [SAMPLE_W-1:0] row_two_above [STORE_DEPTH];
    logic [SAMPLE_W-1:0] win [CH_SLOTS][3][3];   // [channel][column][row]

    int unsigned in_row, in_col, in_chan, out_count;
    out_item_t   sharpened_q[$];
    int          fail_count;

    function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic restart_frame();
        in_row    = 0;
        in_col    = 0;
        in_chan   = 0;
        out_count = 0;
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = val[WIDTH_CFG_W-1:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = val[HEIGHT_W-1:0];
                restart_frame();
            end
            CFG_CHANNEL_COUNT: begin
                chan_reg = val[NC_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic advance_sharpen(in_item_t req);
        int unsigned         w, h, nc, total, lag, k, orow, ocol, c, r;
        logic [SAMPLE_W-1:0] top, mid;
        int                  v;
        bit                  emit;
        out_item_t           res;

        w     = saturate(width_reg, 3, DEF_MAX_WIDTH);
        h     = saturate(height_reg, 3, MAX_HEIGHT);
        nc    = saturate(chan_reg, 1, DEF_MAX_CHANNELS);
        total = w * h * nc;
        lag   = (w + 1) * nc;
        emit  = 1'b0;
        res.sharpened_sample = '0;

        if (out_count < total - lag && req.operation == OP_SAMPLE) begin
            k   = (in_col * nc + in_chan) % STORE_DEPTH;
            top = row_two_above[k];
            mid = row_above[k];
            row_two_above[k] = mid;
            row_above[k]     = req.pixel_sample;
            for (c = 0; c < 2; c++) begin
                for (r = 0; r < 3; r++) begin
                    win[in_chan][c][r] = win[in_chan][c+1][r];
                end
            end
            win[in_chan][2][0] = top;
            win[in_chan][2][1] = mid;
            win[in_chan][2][2] = req.pixel_sample;

            if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
                emit = 1'b1;
                // result belongs to the sample one line plus one pixel back
                if (in_col >= 1) begin
                    orow = in_row - 1;
                    ocol = in_col - 1;
                end else begin
                    orow = in_row - 2;
                    ocol = w - 1;
                end
                if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2) begin
                    v = 5 * int'(win[in_chan][1][1])
                        - int'(win[in_chan][0][1]) - int'(win[in_chan][2][1])
                        - int'(win[in_chan][1][0]) - int'(win[in_chan][1][2]);
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    res.sharpened_sample = v[SAMPLE_W-1:0];
                end
            end

            in_chan++;
            if (in_chan >= nc) begin
                in_chan = 0;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h) in_row = 0;
                end
            end
        end else if (out_count >= total - lag) begin
            // trailing border output, request data does not matter
            emit = 1'b1;
        end

        if (emit) begin
            res.frame_last = (out_count == total - 1);
            if (out_count >= total - 1) restart_frame();
            else out_count++;
            sharpened_q.push_back(res);
        end
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (sharpened_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing outstanding", got));
        end else begin
            want = sharpened_q.pop_front();
            if (got.sharpened_sample !== want.sharpened_sample) begin
                report_mismatch($sformatf("sharpened_sample %h, expected %h",
                                          got.sharpened_sample, want.sharpened_sample));
            end
            if (got.frame_last !== want.frame_last) begin
                report_mismatch($sformatf("frame_last %b, expected %b",
                                          got.frame_last, want.frame_last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 12'd640;
            height_reg = 13'd480;
            chan_reg   = 3'd1;
            for (int c = 0; c < CH_SLOTS; c++) begin
                for (int j = 0; j < 9; j++) begin
                    win[c][j/3][j%3] = '0;
                end
            end
            restart_frame();
            sharpened_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) apply_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready) advance_sharpen(s_item);
            if (m_valid && m_ready) check_result(m_item);
        end
        outstanding <= sharpened_q.size();
        failures    <= fail_count;
    end

    // entries never written stay at zero; rows that read them never reach a result
    initial begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            row_above[k]     = '0;
            row_two_above[k] = '0;
        end
    end

endmodule

### tb/laplacian_sharpen_3x3_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_tb
// Stimulus and verdict for the streaming 3x3 sharpen block.
// ----------------------------------------------------------------------------
// Runs two hand-built 3x3 frames that drive the clamp to both ends, ignored
// flushes, samples past the frame end and a write to an unmapped register;
// then the widest rows with all four channels and the tallest frame, both cut
// short, and many small random frames, some broken off and restarted by a
// register write. Sender gaps and receiver stalls change from frame to frame.
// The checker beside the block does all predicting and comparing.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_tb
    import lapsh_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1200;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_item;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_item;

    int          failures;
    int          outstanding;
    int          gap_pct;
    int          stall_pct;
    int          idle_cycles;
    int unsigned frame_w, frame_h, frame_nc;
    int unsigned items_sent;

    laplacian_sharpen_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    lapsh_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[laplacian_sharpen_3x3] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_request(op_t op, logic [SAMPLE_W-1:0] pix);
        in_item_t req;
        req.operation    = op;
        req.pixel_sample = pix;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait out every queued result, then the pipeline tail
    task automatic drain_to_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic configure(int unsigned w_raw, int unsigned h_raw, int unsigned nc_raw);
        drain_to_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_raw));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(nc_raw));
        cfg_we   <= 1'b0;
        frame_w  = saturate(w_raw & 12'hFFF, 3, DEF_MAX_WIDTH);
        frame_h  = saturate(h_raw & 13'h1FFF, 3, MAX_HEIGHT);
        frame_nc = saturate(nc_raw & 3'h7, 1, DEF_MAX_CHANNELS);
    endtask

    // n_samples short of the frame leaves it broken off; a full frame is drained
    task automatic send_frame(int unsigned n_samples);
        int unsigned total, lag, i;
        total = frame_w * frame_h * frame_nc;
        lag   = (frame_w + 1) * frame_nc;
        for (i = 0; i < n_samples; i++) begin
            if ($urandom_range(19) == 0) begin
                send_request(OP_FLUSH, SAMPLE_W'($urandom_range(255)));
            end
            send_request(OP_SAMPLE, pick_pixel());
        end
        items_sent += n_samples;
        if (n_samples == total) begin
            // a sample past the frame end drains like a flush
            for (i = 0; i < lag; i++) begin
                send_request($urandom_range(1) ? OP_FLUSH : OP_SAMPLE,
                             SAMPLE_W'($urandom_range(255)));
            end
            items_sent += lag;
        end
    endtask

    initial begin
        int unsigned i, frame_no, total;
        bit          restart_needed, broken;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        gap_pct   = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // smallest frame: only the centre pixel is interior
        configure(0, 0, 0);
        send_request(OP_FLUSH, 8'hFF);
        for (i = 0; i < 6; i++) send_request(OP_SAMPLE, (i % 2) ? 8'hFF : 8'h00);
        // unmapped register must not restart the frame
        drain_to_idle();
        write_reg(CFG_UNMAPPED, 13'h1FFF);
        cfg_we <= 1'b0;
        for (i = 6; i < 9; i++) send_request(OP_SAMPLE, (i % 2) ? 8'hFF : 8'h00);
        send_request(OP_FLUSH, 8'h00);
        send_request(OP_SAMPLE, 8'hA5);
        send_request(OP_FLUSH, 8'hFF);
        send_request(OP_SAMPLE, 8'h5A);
        // bright centre on black clamps high
        for (i = 0; i < 9; i++) send_request(OP_SAMPLE, (i == 4) ? 8'hFF : 8'h00);
        for (i = 0; i < 4; i++) send_request(OP_FLUSH, 8'h00);

        // widest rows, all channels, broken off in the first row
        configure(4095, 3, 7);
        send_frame(400);

        // tallest frame, broken off and restarted below
        gap_pct   = 18;
        stall_pct = 18;
        configure(3, 8191, 1);
        send_frame(50);

        frame_no       = 0;
        restart_needed = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            case (frame_no % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 67; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 67; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            if (restart_needed || $urandom_range(2) == 0) begin
                if ($urandom_range(7) == 0) configure($urandom_range(40), $urandom_range(4),
                                                      $urandom_range(7));
                else configure($urandom_range(14), $urandom_range(8), $urandom_range(7));
            end
            total  = frame_w * frame_h * frame_nc;
            broken = ($urandom_range(9) == 0);
            send_frame(broken ? $urandom_range(total - 1) : total);
            restart_needed = broken;
            frame_no++;
        end

        drain_to_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("[laplacian_sharpen_3x3] OK");
        end else begin
            $display("[laplacian_sharpen_3x3] ERROR");
        end
        $finish;
    end

endmodule
